@@ hdl/bba_pkg.sv @@
package bba_pkg;

    localparam int MAX_ORDER_DEF = 10;

    localparam int ACT_W  = 1;
    localparam int SIZE_W = 11;
    localparam int ADDR_W = 10;
    localparam int ORD_W  = 4;
    localparam int ST_W   = 2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_BADFREE = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic a_start;
        logic scan_hit;
        logic scan_next;
        logic split_wr;
        logic alloc_wr;
        logic f_ok;
        logic mrg_rd;
        logic mrg_take;
        logic mrg_end;
        logic fail_nospace;
        logic fail_badfree;
        logic res_take;
    } bba_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_alloc;
        logic no_space;
        logic bit_q;
        logic split_done;
        logic addr_bad;
        logic flag_q;
        logic ord_max;
    } bba_stat_t;

endpackage

@@ hdl/bba_datapath.sv @@
module bba_datapath #(
    parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bba_pkg::bba_cmd_t          cmd,
    output bba_pkg::bba_stat_t         stat,
    input  logic [bba_pkg::ACT_W-1:0]  action,
    input  logic [bba_pkg::SIZE_W-1:0] size_request,
    input  logic [bba_pkg::ADDR_W-1:0] free_address,
    output logic [bba_pkg::ST_W-1:0]   res_status,
    output logic [bba_pkg::ADDR_W-1:0] res_address,
    output logic [bba_pkg::ORD_W-1:0]  res_order
);

    localparam int M     = MAX_ORDER;
    localparam int NW    = M + 1;
    localparam int NODES = (1 << (M + 1)) - 1;
    localparam int OW    = $clog2(M + 1);
    localparam int CW    = (M + 2 > bba_pkg::SIZE_W + 1) ? M + 2 : bba_pkg::SIZE_W + 1;
    localparam int XW    = (M > bba_pkg::ADDR_W) ? M + 1 : bba_pkg::ADDR_W + 1;

    logic                free_mem  [NODES];
    logic                flag_mem  [1 << M];
    logic [OW-1:0]       order_mem [1 << M];

    logic [NW-1:0]       clr_reg;
    logic [NW:0]         cnt_reg [M+1];
    logic [NW:0]         cnt_next [M+1];

    logic [bba_pkg::ACT_W-1:0]  act_reg;
    logic [bba_pkg::SIZE_W-1:0] size_reg;
    logic [bba_pkg::ADDR_W-1:0] faddr_reg;
    logic [OW-1:0]       t_reg, k_reg, j_reg, ord_reg;
    logic [M-1:0]        i_reg, a_reg;
    logic                bit_q, flag_q;
    logic [OW-1:0]       order_q;

    logic [CW-1:0]       need;
    logic                too_big, found;
    logic [OW-1:0]       t_c, k_c;
    logic [M-1:0]        faddr_m;
    logic [OW-1:0]       jm1;
    logic [NW-1:0]       scan_node, split_node, bud_node, end_node, rd_node, wr_node;
    logic                wr_en, wr_bit;

    function automatic logic [NW-1:0] node_of(input logic [OW-1:0] ord,
                                              input logic [M-1:0] off);
        logic [NW-1:0] b;
        b = (NW'(1) << (M - int'(ord))) - NW'(1);
        return b + NW'(off >> ord);
    endfunction

    always_comb
    begin
        need    = CW'(size_reg) + CW'(1);
        too_big = need > (CW'(1) << M);
        t_c     = OW'(M);
        for (int q = M; q >= 0; q--)
        begin
            if ((CW'(1) << q) >= need)
                t_c = OW'(q);
        end
        k_c   = '0;
        found = 1'b0;
        for (int q = M; q >= 0; q--)
        begin
            if (OW'(q) >= t_c && cnt_reg[q] != '0)
            begin
                k_c   = OW'(q);
                found = 1'b1;
            end
        end
    end

    assign faddr_m    = M'(faddr_reg);
    assign jm1        = j_reg - OW'(1);
    assign scan_node  = node_of(k_reg, '0) + NW'(i_reg);
    assign split_node = node_of(jm1, a_reg | (M'(1) << jm1));
    assign bud_node   = node_of(ord_reg, a_reg ^ (M'(1) << ord_reg));
    assign end_node   = node_of(ord_reg, a_reg);
    assign rd_node    = cmd.mrg_rd ? bud_node : scan_node;

    always_comb
    begin
        wr_en   = 1'b1;
        wr_bit  = 1'b0;
        wr_node = scan_node;
        priority if (cmd.clr_step)
        begin
            wr_node = clr_reg;
            wr_bit  = (clr_reg == '0);
        end
        else if (cmd.scan_hit)
            wr_node = scan_node;
        else if (cmd.split_wr)
        begin
            wr_node = split_node;
            wr_bit  = 1'b1;
        end
        else if (cmd.mrg_take)
            wr_node = bud_node;
        else if (cmd.mrg_end)
        begin
            wr_node = end_node;
            wr_bit  = 1'b1;
        end
        else
            wr_en = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            free_mem[wr_node] <= wr_bit;
        bit_q <= free_mem[rd_node];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            flag_mem[clr_reg[M-1:0]] <= 1'b0;
        else if (cmd.alloc_wr)
            flag_mem[a_reg] <= 1'b1;
        else if (cmd.f_ok)
            flag_mem[faddr_m] <= 1'b0;
        flag_q <= flag_mem[faddr_m];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc_wr)
            order_mem[a_reg] <= t_reg;
        order_q <= order_mem[faddr_m];
    end

    always_comb
    begin
        for (int q = 0; q <= M; q++)
        begin
            cnt_next[q] = cnt_reg[q];
            if ((cmd.scan_hit && k_reg == OW'(q)) || (cmd.mrg_take && ord_reg == OW'(q)))
                cnt_next[q] = cnt_reg[q] - (NW+1)'(1);
            if ((cmd.split_wr && jm1 == OW'(q)) || (cmd.mrg_end && ord_reg == OW'(q)))
                cnt_next[q] = cnt_reg[q] + (NW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            for (int q = 0; q <= M; q++)
                cnt_reg[q] <= (q == M) ? (NW+1)'(1) : '0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_reg <= clr_reg + NW'(1);
            for (int q = 0; q <= M; q++)
                cnt_reg[q] <= cnt_next[q];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= action;
            size_reg  <= size_request;
            faddr_reg <= free_address;
        end
        if (cmd.a_start)
        begin
            t_reg <= t_c;
            k_reg <= k_c;
            i_reg <= '0;
        end
        if (cmd.scan_next)
            i_reg <= i_reg + M'(1);
        if (cmd.scan_hit)
        begin
            a_reg <= i_reg << k_reg;
            j_reg <= k_reg;
        end
        if (cmd.split_wr)
            j_reg <= jm1;
        if (cmd.f_ok)
        begin
            a_reg   <= faddr_m;
            ord_reg <= order_q;
        end
        if (cmd.mrg_take)
        begin
            a_reg   <= a_reg & ~(M'(1) << ord_reg);
            ord_reg <= ord_reg + OW'(1);
        end
        if (cmd.alloc_wr)
        begin
            res_status  <= bba_pkg::ST_OK;
            res_address <= bba_pkg::ADDR_W'(a_reg);
            res_order   <= bba_pkg::ORD_W'(t_reg);
        end
        else if (cmd.mrg_end)
        begin
            res_status  <= bba_pkg::ST_OK;
            res_address <= bba_pkg::ADDR_W'(a_reg);
            res_order   <= bba_pkg::ORD_W'(ord_reg);
        end
        else if (cmd.fail_nospace || cmd.fail_badfree)
        begin
            res_status  <= cmd.fail_nospace ? bba_pkg::ST_NOSPACE : bba_pkg::ST_BADFREE;
            res_address <= '0;
            res_order   <= '0;
        end
    end

    assign stat.clr_done   = (clr_reg == NW'(NODES - 1));
    assign stat.is_alloc   = (act_reg == bba_pkg::ACT_ALLOC);
    assign stat.no_space   = too_big | ~found;
    assign stat.bit_q      = bit_q;
    assign stat.split_done = (j_reg == t_reg);
    assign stat.addr_bad   = XW'(faddr_reg) >= (XW'(1) << M);
    assign stat.flag_q     = flag_q;
    assign stat.ord_max    = (ord_reg == OW'(M));

endmodule

@@ hdl/bba_ctrl.sv @@
module bba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  bba_pkg::bba_stat_t stat,
    output bba_pkg::bba_cmd_t  cmd
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_SRD   = 4'd3;
    localparam logic [3:0] S_SCHK  = 4'd4;
    localparam logic [3:0] S_SPLIT = 4'd5;
    localparam logic [3:0] S_AWR   = 4'd6;
    localparam logic [3:0] S_FRD   = 4'd7;
    localparam logic [3:0] S_FCHK  = 4'd8;
    localparam logic [3:0] S_MRD   = 4'd9;
    localparam logic [3:0] S_MCHK  = 4'd10;
    localparam logic [3:0] S_MEND  = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (!stat.is_alloc)
                    state_next = S_FRD;
                else if (stat.no_space)
                begin
                    cmd.fail_nospace = 1'b1;
                    state_next       = S_FIN;
                end
                else
                begin
                    cmd.a_start = 1'b1;
                    state_next  = S_SRD;
                end
            end
            S_SRD:
            begin
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (stat.bit_q)
                begin
                    cmd.scan_hit = 1'b1;
                    state_next   = S_SPLIT;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SRD;
                end
            end
            S_SPLIT:
            begin
                if (stat.split_done)
                    state_next = S_AWR;
                else
                    cmd.split_wr = 1'b1;
            end
            S_AWR:
            begin
                cmd.alloc_wr = 1'b1;
                state_next   = S_FIN;
            end
            S_FRD:
            begin
                if (stat.addr_bad)
                begin
                    cmd.fail_badfree = 1'b1;
                    state_next       = S_FIN;
                end
                else
                    state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (stat.flag_q)
                begin
                    cmd.f_ok   = 1'b1;
                    state_next = S_MRD;
                end
                else
                begin
                    cmd.fail_badfree = 1'b1;
                    state_next       = S_FIN;
                end
            end
            S_MRD:
            begin
                if (stat.ord_max)
                    state_next = S_MEND;
                else
                begin
                    cmd.mrg_rd = 1'b1;
                    state_next = S_MCHK;
                end
            end
            S_MCHK:
            begin
                if (stat.bit_q)
                begin
                    cmd.mrg_take = 1'b1;
                    state_next   = S_MRD;
                end
                else
                    state_next = S_MEND;
            end
            S_MEND:
            begin
                cmd.mrg_end = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_take   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/bba_out.sv @@
module bba_out (
    input  logic                       clk,
    input  logic                       load,
    input  logic [bba_pkg::ST_W-1:0]   res_status,
    input  logic [bba_pkg::ADDR_W-1:0] res_address,
    input  logic [bba_pkg::ORD_W-1:0]  res_order,
    output logic [bba_pkg::ST_W-1:0]   status,
    output logic [bba_pkg::ADDR_W-1:0] block_address,
    output logic [bba_pkg::ORD_W-1:0]  block_order
);

    logic [bba_pkg::ST_W-1:0]   status_reg;
    logic [bba_pkg::ADDR_W-1:0] address_reg;
    logic [bba_pkg::ORD_W-1:0]  order_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= res_status;
            address_reg <= res_address;
            order_reg   <= res_order;
        end
    end

    assign status        = status_reg;
    assign block_address = address_reg;
    assign block_order   = order_reg;

endmodule

@@ hdl/buddy_block_allocator_unit.sv @@
// Buddy allocator over 2^MAX_ORDER units. After reset the free map is cleared, with in_ready
// low until the clear is done. An allocate scans the free-map entries at the chosen order,
// from the lowest, until the lowest free block is found (each entry is read and then checked
// through the single memory read port), and then splits it down to the needed order. A free
// merges level by level, one buddy read and check per level, while the buddy is free. A
// failed request goes to the output without a scan or merge. One item is in
// flight at a time; a finished result waits in the output register.
module buddy_block_allocator_unit #(
    parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [bba_pkg::ACT_W-1:0]  action,
    input  logic [bba_pkg::SIZE_W-1:0] size_request,
    input  logic [bba_pkg::ADDR_W-1:0] free_address,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [bba_pkg::ST_W-1:0]   status,
    output logic [bba_pkg::ADDR_W-1:0] block_address,
    output logic [bba_pkg::ORD_W-1:0]  block_order
);

    bba_pkg::bba_cmd_t          cmd;
    bba_pkg::bba_stat_t         stat;
    logic [bba_pkg::ST_W-1:0]   res_status;
    logic [bba_pkg::ADDR_W-1:0] res_address;
    logic [bba_pkg::ORD_W-1:0]  res_order;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bba_datapath #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .size_request (size_request),
        .free_address (free_address),
        .res_status   (res_status),
        .res_address  (res_address),
        .res_order    (res_order)
    );

    bba_out u_out (
        .clk           (clk),
        .load          (cmd.res_take),
        .res_status    (res_status),
        .res_address   (res_address),
        .res_order     (res_order),
        .status        (status),
        .block_address (block_address),
        .block_order   (block_order)
    );

endmodule
